@@ rtl/tls_sni_pkg.sv @@
// types, constants and the truncation status function for the tls server-name extractor
package tls_sni_pkg;

  // width of the length counters; loaded lengths keep only the low bits
  localparam int unsigned LenCntW = 16;

  localparam logic [7:0] RecTypeHandshake = 8'h16;
  localparam logic [7:0] RecVersionMajor  = 8'h03;
  localparam int unsigned HsHdrLen        = 38;

  // result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [3:0] {
    StFound       = 4'd0,
    StBadHeader   = 4'd1,
    StTruncHs     = 4'd2,
    StTruncSidLen = 4'd3,
    StTruncSid    = 4'd4,
    StTruncCs     = 4'd5,
    StTruncCm     = 4'd6,
    StTruncExt    = 4'd7,
    StBadSni      = 4'd8,
    StNameOverrun = 4'd9,
    StNoSni       = 4'd10
  } status_e;

  typedef enum logic [12:0] {
    PhRec     = 13'b0000000000001,
    PhHs      = 13'b0000000000010,
    PhSidLen  = 13'b0000000000100,
    PhSid     = 13'b0000000001000,
    PhCsLen   = 13'b0000000010000,
    PhCs      = 13'b0000000100000,
    PhCmLen   = 13'b0000001000000,
    PhCm      = 13'b0000010000000,
    PhExtLen  = 13'b0000100000000,
    PhExtHdr  = 13'b0001000000000,
    PhExtBody = 13'b0010000000000,
    PhSni     = 13'b0100000000000,
    PhDone    = 13'b1000000000000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } sni_in_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] name_byte;
    logic [3:0] status_code;
    logic       final_result;
  } sni_out_t;

  // status given when the buffer ends inside a phase
  function automatic status_e trunc_code(phase_e ph);
    status_e code;
    case (ph)
      PhRec:     code = StBadHeader;
      PhHs:      code = StTruncHs;
      PhSidLen:  code = StTruncSidLen;
      PhSid:     code = StTruncSid;
      PhCsLen:   code = StTruncSid;
      PhCs:      code = StTruncCs;
      PhCmLen:   code = StTruncCs;
      PhCm:      code = StTruncCm;
      PhExtLen:  code = StTruncCm;
      PhExtHdr:  code = StNoSni;
      PhExtBody: code = StTruncExt;
      PhSni:     code = StTruncExt;
      default:   code = StFound;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/tls_client_hello_sni_extractor.sv @@
// tls client hello parser that streams out the server name and a status item
//
// Takes one record byte per cycle and parses it in the same cycle against the
// stored parse state; the hostname byte and/or status item it produces go into
// a four-entry result queue that feeds the output channel. A byte is taken in
// every cycle while the queue has at least two free entries, so the sustained
// rate is one byte per cycle as long as the consumer takes one item per cycle.
// A byte that gives two items (a hostname byte that also ends the message or
// the buffer) leaves one more item to drain, which the queue absorbs.
module tls_client_hello_sni_extractor
  import tls_sni_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sni_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sni_out_t out_data_o
);

  // parse state
  phase_e             phase_q, phase_d;
  logic [LenCntW-1:0] skip_q, skip_d;
  logic [7:0]         len_hi_q, len_hi_d;
  logic [LenCntW-1:0] ext_rem_q, ext_rem_d;
  logic [LenCntW-1:0] host_rem_q, host_rem_d;
  logic [2:0]         idx_q, idx_d;
  logic               bad_type_q, bad_type_d;
  logic               msg_done_q, msg_done_d;
  logic               type_zero_q, type_zero_d;

  // result queue
  sni_out_t           q_mem [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q;

  logic               in_fire, out_fire;
  logic [7:0]         b;
  logic [15:0]        v16;
  logic [1:0]         n_res;
  sni_out_t           res [2];

  assign in_ready_o = (cnt_q <= QCntW'(QDepth - 2));
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_fire   = out_valid_o && out_ready_i;
  assign out_data_o = q_mem[rd_ptr_q];

  assign b   = in_data_i.data_byte;
  assign v16 = {len_hi_q, b};

  always_comb begin
    phase_d     = phase_q;
    skip_d      = skip_q;
    len_hi_d    = len_hi_q;
    ext_rem_d   = ext_rem_q;
    host_rem_d  = host_rem_q;
    idx_d       = idx_q;
    bad_type_d  = bad_type_q;
    msg_done_d  = msg_done_q;
    type_zero_d = type_zero_q;
    n_res       = 2'd0;
    res[0]      = '0;
    res[1]      = '0;

    case (phase_q)
      PhRec: begin
        if ((idx_q == 3'd0 && b != RecTypeHandshake) ||
            (idx_q == 3'd1 && b != RecVersionMajor)) begin
          res[0]     = '{is_status: 1'b1, name_byte: 8'h00,
                         status_code: StBadHeader, final_result: 1'b1};
          n_res      = 2'd1;
          phase_d    = PhDone;
          msg_done_d = 1'b1;
        end else if (idx_q >= 3'd4) begin
          skip_d  = LenCntW'(HsHdrLen);
          idx_d   = 3'd0;
          phase_d = PhHs;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      PhHs, PhSid, PhCs, PhCm: begin
        skip_d = skip_q - LenCntW'(1);
        if (skip_d == '0) begin
          idx_d = 3'd0;
          case (phase_q)
            PhHs:    phase_d = PhSidLen;
            PhSid:   phase_d = PhCsLen;
            PhCs:    phase_d = PhCmLen;
            default: phase_d = PhExtLen;
          endcase
        end
      end
      PhSidLen, PhCmLen: begin
        skip_d = LenCntW'(b);
        idx_d  = 3'd0;
        if (phase_q == PhSidLen) begin
          phase_d = (skip_d == '0) ? PhCsLen : PhSid;
        end else begin
          phase_d = (skip_d == '0) ? PhExtLen : PhCm;
        end
      end
      PhCsLen: begin
        if (idx_q == 3'd0) begin
          len_hi_d = b;
          idx_d    = 3'd1;
        end else begin
          skip_d  = v16[LenCntW-1:0];
          idx_d   = 3'd0;
          phase_d = (skip_d == '0) ? PhCmLen : PhCs;
        end
      end
      PhExtLen: begin
        if (idx_q == 3'd0) begin
          idx_d = 3'd1;
        end else begin
          idx_d   = 3'd0;
          phase_d = PhExtHdr;
        end
      end
      PhExtHdr: begin
        if (idx_q == 3'd0 || idx_q == 3'd2) begin
          len_hi_d = b;
          idx_d    = idx_q + 3'd1;
        end else if (idx_q == 3'd1) begin
          // extension type, kept until the header ends
          type_zero_d = (v16 == 16'h0000);
          idx_d       = 3'd2;
        end else begin
          ext_rem_d = v16[LenCntW-1:0];
          idx_d     = 3'd0;
          if (type_zero_q) begin
            bad_type_d = 1'b0;
            host_rem_d = '0;
            phase_d    = PhSni;
            if (ext_rem_d == '0) begin
              res[0]     = '{is_status: 1'b1, name_byte: 8'h00,
                             status_code: StBadSni, final_result: 1'b1};
              n_res      = 2'd1;
              phase_d    = PhDone;
              msg_done_d = 1'b1;
            end
          end else begin
            phase_d = (ext_rem_d == '0) ? PhExtHdr : PhExtBody;
          end
        end
      end
      PhExtBody: begin
        ext_rem_d = ext_rem_q - LenCntW'(1);
        if (ext_rem_d == '0) begin
          idx_d   = 3'd0;
          phase_d = PhExtHdr;
        end
      end
      PhSni: begin
        if (idx_q < 3'd5) begin
          // list header: byte 2 name type, bytes 3 and 4 hostname length
          if (idx_q == 3'd2) bad_type_d = (b != 8'h00);
          if (idx_q == 3'd3) len_hi_d = b;
          if (idx_q == 3'd4) host_rem_d = v16[LenCntW-1:0];
          idx_d = idx_q + 3'd1;
        end else if (!bad_type_q && host_rem_q != '0) begin
          res[0]     = '{is_status: 1'b0, name_byte: b,
                         status_code: StFound, final_result: 1'b0};
          n_res      = 2'd1;
          host_rem_d = host_rem_q - LenCntW'(1);
        end
        ext_rem_d = ext_rem_q - LenCntW'(1);
        if (ext_rem_d == '0) begin
          res[n_res[0]].is_status    = 1'b1;
          res[n_res[0]].name_byte    = 8'h00;
          res[n_res[0]].final_result = 1'b1;
          if (idx_d < 3'd5 || bad_type_d) begin
            res[n_res[0]].status_code = StBadSni;
          end else if (host_rem_d != '0) begin
            res[n_res[0]].status_code = StNameOverrun;
          end else begin
            res[n_res[0]].status_code = StFound;
          end
          n_res      = n_res + 2'd1;
          phase_d    = PhDone;
          msg_done_d = 1'b1;
        end
      end
      default: begin
        // message over: ignore bytes until the end of the buffer
      end
    endcase

    if (in_data_i.end_of_buffer) begin
      if (!msg_done_d) begin
        res[n_res[0]].is_status    = 1'b1;
        res[n_res[0]].name_byte    = 8'h00;
        res[n_res[0]].status_code  = trunc_code(phase_d);
        res[n_res[0]].final_result = 1'b1;
        n_res = n_res + 2'd1;
      end
      phase_d     = PhRec;
      skip_d      = '0;
      len_hi_d    = '0;
      ext_rem_d   = '0;
      host_rem_d  = '0;
      idx_d       = 3'd0;
      bad_type_d  = 1'b0;
      msg_done_d  = 1'b0;
      type_zero_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhRec;
      skip_q      <= '0;
      len_hi_q    <= '0;
      ext_rem_q   <= '0;
      host_rem_q  <= '0;
      idx_q       <= 3'd0;
      bad_type_q  <= 1'b0;
      msg_done_q  <= 1'b0;
      type_zero_q <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      skip_q      <= skip_d;
      len_hi_q    <= len_hi_d;
      ext_rem_q   <= ext_rem_d;
      host_rem_q  <= host_rem_d;
      idx_q       <= idx_d;
      bad_type_q  <= bad_type_d;
      msg_done_q  <= msg_done_d;
      type_zero_q <= type_zero_d;
    end
  end

  // queue storage, up to two items written per byte
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (n_res != 2'd0) q_mem[wr_ptr_q] <= res[0];
      if (n_res == 2'd2) q_mem[wr_ptr_q + QPtrW'(1)] <= res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_fire) wr_ptr_q <= wr_ptr_q + QPtrW'(n_res);
      if (out_fire) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      cnt_q <= cnt_q + (in_fire ? QCntW'(n_res) : QCntW'(0))
                     - (out_fire ? QCntW'(1) : QCntW'(0));
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.end_of_buffer |=> phase_q == PhRec && idx_q == 3'd0 && !msg_done_q)
    else $error("parser not restarted after end of buffer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDone) == msg_done_q)
    else $error("done phase and finished flag disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.end_of_buffer && !msg_done_q |-> n_res != 2'd0)
    else $error("buffer ended without a status item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("parse phase not one-hot");
`endif

endmodule
